### rtl/lom_pkg.sv
// Shared types and defaults for the limit order matcher.
package lom_pkg;

    localparam int BookDepthDef = 32;
    localparam int PriceBitsDef = 32;
    localparam int QtyBitsDef   = 32;
    localparam int IdBits       = 32;

    // Operation applied to a whole book.
    typedef enum logic [1:0] {
        BK_HOLD = 2'd0,
        BK_POP  = 2'd1,
        BK_DEC  = 2'd2,
        BK_INS  = 2'd3
    } book_op_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_TRADE = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MATCH = 1'b1
    } state_t;

endpackage

### rtl/limit_order_matcher.sv
// Price-time priority limit order book with matching, top level.
// Latency: the acknowledgement beat is ready the cycle after the order beat is taken.
// A new order is taken only in idle, once the last one is through; every result beat
// passes the single output register, and matching waits while that register is stalled.
// Insertion shifts the sorted cell row in place; each fill pops or decrements the book head.
// Reset (aresetn low, synchronous) empties both books and sets order and trade ids to 1.
module limit_order_matcher #(
    parameter int BOOK_DEPTH = lom_pkg::BookDepthDef,
    parameter int PRICE_BITS = lom_pkg::PriceBitsDef,
    parameter int QTY_BITS   = lom_pkg::QtyBitsDef
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // side[0], price[32:1], quantity[64:33], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // order_id[31:0], trade_num[63:32],
                                    // buyer_id[95:64], seller_id[127:96],
                                    // exec_price[159:128], exec_quantity[191:160]
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast
);
    import lom_pkg::*;

    function automatic logic crosses(input logic sell, input logic [PRICE_BITS-1:0] lim,
                                     input logic [PRICE_BITS-1:0] p);
        crosses = sell ? (p >= lim) : (p <= lim);
    endfunction

    // Unpack the order beat; only the low bits of each field count.
    logic                  in_side;
    logic [PRICE_BITS-1:0] in_price;
    logic [QTY_BITS-1:0]   in_qty;
    assign in_side  = s_tdata[0];
    assign in_price = PRICE_BITS'(s_tdata[32:1]);
    assign in_qty   = QTY_BITS'(s_tdata[64:33]);

    state_t                state_reg, state_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    logic [IdBits-1:0]     oid_reg, oid_next;
    logic [IdBits-1:0]     next_oid_reg, next_oid_next;
    logic [IdBits-1:0]     next_tid_reg, next_tid_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [IdBits-1:0]     out_oid_reg, out_oid_next;
    logic [IdBits-1:0]     out_tid_reg, out_tid_next;
    logic [IdBits-1:0]     out_buy_reg, out_buy_next;
    logic [IdBits-1:0]     out_sell_reg, out_sell_next;
    logic [31:0]           out_px_reg, out_px_next;
    logic [31:0]           out_qty_reg, out_qty_next;
    logic                  out_last_reg, out_last_next;

    // Book status.
    book_op_t              bid_op, ask_op;
    logic [QTY_BITS-1:0]   dec_amt;
    logic                  bid_hv, bid_sv, bid_full, ask_hv, ask_sv, ask_full;
    logic [PRICE_BITS-1:0] bid_hp, bid_sp, ask_hp, ask_sp;
    logic [QTY_BITS-1:0]   bid_hq, ask_hq;
    logic [IdBits-1:0]     bid_hi, ask_hi;

    lom_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .DESCENDING (1'b1)
    ) u_bid (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (bid_op),
        .ins_price    (price_reg),
        .ins_qty      (qty_reg),
        .ins_id       (oid_reg),
        .dec_qty      (dec_amt),
        .head_valid   (bid_hv),
        .head_price   (bid_hp),
        .head_qty     (bid_hq),
        .head_id      (bid_hi),
        .second_valid (bid_sv),
        .second_price (bid_sp),
        .full         (bid_full)
    );

    lom_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .DESCENDING (1'b0)
    ) u_ask (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (ask_op),
        .ins_price    (price_reg),
        .ins_qty      (qty_reg),
        .ins_id       (oid_reg),
        .dec_qty      (dec_amt),
        .head_valid   (ask_hv),
        .head_price   (ask_hp),
        .head_qty     (ask_hq),
        .head_id      (ask_hi),
        .second_valid (ask_sv),
        .second_price (ask_sp),
        .full         (ask_full)
    );

    // Opposite book head as seen by the order in flight.
    logic                  opp_hv, opp_sv, own_full;
    logic [PRICE_BITS-1:0] opp_hp, opp_sp;
    logic [QTY_BITS-1:0]   opp_hq;
    logic [IdBits-1:0]     opp_hi;
    assign opp_hv   = side_reg ? bid_hv : ask_hv;
    assign opp_sv   = side_reg ? bid_sv : ask_sv;
    assign opp_hp   = side_reg ? bid_hp : ask_hp;
    assign opp_sp   = side_reg ? bid_sp : ask_sp;
    assign opp_hq   = side_reg ? bid_hq : ask_hq;
    assign opp_hi   = side_reg ? bid_hi : ask_hi;
    assign own_full = side_reg ? ask_full : bid_full;

    // Acknowledgement is last when nothing trades and the remainder rests quietly.
    logic in_cross, in_own_full, ack_last;
    assign in_cross = (in_qty != '0) &&
                      (in_side ? (bid_hv && crosses(1'b1, in_price, bid_hp))
                               : (ask_hv && crosses(1'b0, in_price, ask_hp)));
    assign in_own_full = in_side ? ask_full : bid_full;
    assign ack_last    = !in_cross && ((in_qty == '0) || !in_own_full);

    // One fill against the opposite head, and what the book looks like after it.
    logic                  cross_now, head_empties, after_v, next_cross, trade_last;
    logic [QTY_BITS-1:0]   fill, rem;
    logic [PRICE_BITS-1:0] after_p;
    assign cross_now    = (qty_reg != '0) && opp_hv && crosses(side_reg, price_reg, opp_hp);
    assign fill         = (opp_hq < qty_reg) ? opp_hq : qty_reg;
    assign rem          = qty_reg - fill;
    assign head_empties = (opp_hq == fill);
    assign after_v      = head_empties ? opp_sv : opp_hv;
    assign after_p      = head_empties ? opp_sp : opp_hp;
    assign next_cross   = (rem != '0) && after_v && crosses(side_reg, price_reg, after_p);
    assign trade_last   = !next_cross && ((rem == '0) || !own_full);
    assign dec_amt      = fill;

    logic out_free, s_accept;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    logic [63:0] px_wide, lim_wide;
    assign px_wide  = 64'(opp_hp);
    assign lim_wide = 64'(price_reg);

    always_comb begin
        state_next     = state_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        qty_next       = qty_reg;
        oid_next       = oid_reg;
        next_oid_next  = next_oid_reg;
        next_tid_next  = next_tid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_oid_next   = out_oid_reg;
        out_tid_next   = out_tid_reg;
        out_buy_next   = out_buy_reg;
        out_sell_next  = out_sell_reg;
        out_px_next    = out_px_reg;
        out_qty_next   = out_qty_reg;
        out_last_next  = out_last_reg;
        bid_op         = BK_HOLD;
        ask_op         = BK_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    side_next      = in_side;
                    price_next     = in_price;
                    qty_next       = in_qty;
                    oid_next       = next_oid_reg;
                    next_oid_next  = next_oid_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_oid_next   = next_oid_reg;
                    out_tid_next   = '0;
                    out_buy_next   = '0;
                    out_sell_next  = '0;
                    out_px_next    = '0;
                    out_qty_next   = '0;
                    out_last_next  = ack_last;
                    state_next     = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (out_free) begin
                    if (cross_now) begin
                        // Trade at the resting price; pop the head once it is used up.
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_TRADE;
                        out_oid_next   = oid_reg;
                        out_tid_next   = next_tid_reg;
                        out_buy_next   = side_reg ? opp_hi : oid_reg;
                        out_sell_next  = side_reg ? oid_reg : opp_hi;
                        out_px_next    = px_wide[31:0];
                        out_qty_next   = 32'(fill);
                        out_last_next  = trade_last;
                        next_tid_next  = next_tid_reg + 1'b1;
                        qty_next       = rem;
                        if (side_reg) begin
                            bid_op = head_empties ? BK_POP : BK_DEC;
                        end else begin
                            ask_op = head_empties ? BK_POP : BK_DEC;
                        end
                    end else begin
                        if (qty_reg != '0) begin
                            if (own_full) begin
                                // Drop the remainder and report it.
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_DROP;
                                out_oid_next   = oid_reg;
                                out_tid_next   = '0;
                                out_buy_next   = '0;
                                out_sell_next  = '0;
                                out_px_next    = lim_wide[31:0];
                                out_qty_next   = 32'(qty_reg);
                                out_last_next  = 1'b1;
                            end else if (side_reg) begin
                                ask_op = BK_INS;
                            end else begin
                                bid_op = BK_INS;
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            next_oid_reg  <= IdBits'(1);
            next_tid_reg  <= IdBits'(1);
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            next_oid_reg  <= next_oid_next;
            next_tid_reg  <= next_tid_next;
        end
    end

    always_ff @(posedge aclk) begin
        side_reg     <= side_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        oid_reg      <= oid_next;
        out_kind_reg <= out_kind_next;
        out_oid_reg  <= out_oid_next;
        out_tid_reg  <= out_tid_next;
        out_buy_reg  <= out_buy_next;
        out_sell_reg <= out_sell_next;
        out_px_reg   <= out_px_next;
        out_qty_reg  <= out_qty_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_qty_reg, out_px_reg, out_sell_reg, out_buy_reg,
                       out_tid_reg, out_oid_reg};

    // An accepted order shows its acknowledgement on the next cycle.
    a_ack_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tvalid && m_tuser == KIND_ACK))
        else $error("acknowledgement missing after accepted order");

    // Every trade advances the trade number by one.
    a_tid_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH && out_free && cross_now) |=>
            (next_tid_reg == $past(next_tid_reg) + 1'b1))
        else $error("trade number did not advance");

    // A trade never grows the open quantity of the order in flight.
    a_qty_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH && out_free && cross_now) |=> (qty_reg < $past(qty_reg)))
        else $error("fill did not reduce order quantity");

endmodule

### rtl/lom_cell.sv
// One book slot: price, quantity, id and valid, shifting with its neighbors.
module lom_cell #(
    parameter int PRICE_BITS = lom_pkg::PriceBitsDef,
    parameter int QTY_BITS   = lom_pkg::QtyBitsDef,
    parameter bit DESCENDING = 1'b1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lom_pkg::book_op_t         op,
    input  logic [PRICE_BITS-1:0]     ins_price,
    input  logic [QTY_BITS-1:0]       ins_qty,
    input  logic [lom_pkg::IdBits-1:0] ins_id,
    input  logic [QTY_BITS-1:0]       dec_qty,
    input  logic [PRICE_BITS-1:0]     l_price,
    input  logic [QTY_BITS-1:0]       l_qty,
    input  logic [lom_pkg::IdBits-1:0] l_id,
    input  logic                      l_valid,
    input  logic                      l_behind,
    input  logic [PRICE_BITS-1:0]     r_price,
    input  logic [QTY_BITS-1:0]       r_qty,
    input  logic [lom_pkg::IdBits-1:0] r_id,
    input  logic                      r_valid,
    output logic [PRICE_BITS-1:0]     price,
    output logic [QTY_BITS-1:0]       qty,
    output logic [lom_pkg::IdBits-1:0] id,
    output logic                      valid,
    output logic                      behind
);
    import lom_pkg::*;

    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    logic [IdBits-1:0]     id_reg, id_next;
    logic                  valid_reg, valid_next;

    // An entry at the same or a better price keeps its place ahead of a new order.
    assign behind = valid_reg && (DESCENDING ? (price_reg >= ins_price)
                                             : (price_reg <= ins_price));

    always_comb begin
        price_next = price_reg;
        qty_next   = qty_reg;
        id_next    = id_reg;
        valid_next = valid_reg;
        case (op)
            BK_POP: begin
                price_next = r_price;
                qty_next   = r_qty;
                id_next    = r_id;
                valid_next = r_valid;
            end
            BK_DEC: begin
                qty_next = qty_reg - dec_qty;
            end
            BK_INS: begin
                if (!behind) begin
                    if (l_behind) begin
                        price_next = ins_price;
                        qty_next   = ins_qty;
                        id_next    = ins_id;
                        valid_next = 1'b1;
                    end else begin
                        price_next = l_price;
                        qty_next   = l_qty;
                        id_next    = l_id;
                        valid_next = l_valid;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
        id_reg    <= id_next;
    end

    assign price = price_reg;
    assign qty   = qty_reg;
    assign id    = id_reg;
    assign valid = valid_reg;

endmodule

### rtl/lom_book.sv
// One side of the book: a sorted row of cells, best entry in cell 0.
module lom_book #(
    parameter int BOOK_DEPTH = lom_pkg::BookDepthDef,
    parameter int PRICE_BITS = lom_pkg::PriceBitsDef,
    parameter int QTY_BITS   = lom_pkg::QtyBitsDef,
    parameter bit DESCENDING = 1'b1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lom_pkg::book_op_t          op,
    input  logic [PRICE_BITS-1:0]      ins_price,
    input  logic [QTY_BITS-1:0]        ins_qty,
    input  logic [lom_pkg::IdBits-1:0] ins_id,
    input  logic [QTY_BITS-1:0]        dec_qty,
    output logic                       head_valid,
    output logic [PRICE_BITS-1:0]      head_price,
    output logic [QTY_BITS-1:0]        head_qty,
    output logic [lom_pkg::IdBits-1:0] head_id,
    output logic                       second_valid,
    output logic [PRICE_BITS-1:0]      second_price,
    output logic                       full
);
    import lom_pkg::*;

    logic [PRICE_BITS-1:0] c_price  [BOOK_DEPTH];
    logic [QTY_BITS-1:0]   c_qty    [BOOK_DEPTH];
    logic [IdBits-1:0]     c_id     [BOOK_DEPTH];
    logic                  c_valid  [BOOK_DEPTH];
    logic                  c_behind [BOOK_DEPTH];

    for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
        book_op_t              cell_op;
        logic [PRICE_BITS-1:0] lp, rp;
        logic [QTY_BITS-1:0]   lq, rq;
        logic [IdBits-1:0]     li, ri;
        logic                  lv, lb, rv;

        // Only the head takes a partial fill.
        assign cell_op = (op == BK_DEC && i != 0) ? BK_HOLD : op;

        if (i == 0) begin : g_first
            assign lp = '0;
            assign lq = '0;
            assign li = '0;
            assign lv = 1'b0;
            assign lb = 1'b1;
        end else begin : g_mid
            assign lp = c_price[i-1];
            assign lq = c_qty[i-1];
            assign li = c_id[i-1];
            assign lv = c_valid[i-1];
            assign lb = c_behind[i-1];
        end

        if (i == BOOK_DEPTH - 1) begin : g_last
            assign rp = '0;
            assign rq = '0;
            assign ri = '0;
            assign rv = 1'b0;
        end else begin : g_inner
            assign rp = c_price[i+1];
            assign rq = c_qty[i+1];
            assign ri = c_id[i+1];
            assign rv = c_valid[i+1];
        end

        lom_cell #(
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS),
            .DESCENDING (DESCENDING)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (cell_op),
            .ins_price (ins_price),
            .ins_qty   (ins_qty),
            .ins_id    (ins_id),
            .dec_qty   (dec_qty),
            .l_price   (lp),
            .l_qty     (lq),
            .l_id      (li),
            .l_valid   (lv),
            .l_behind  (lb),
            .r_price   (rp),
            .r_qty     (rq),
            .r_id      (ri),
            .r_valid   (rv),
            .price     (c_price[i]),
            .qty       (c_qty[i]),
            .id        (c_id[i]),
            .valid     (c_valid[i]),
            .behind    (c_behind[i])
        );
    end

    assign head_valid   = c_valid[0];
    assign head_price   = c_price[0];
    assign head_qty     = c_qty[0];
    assign head_id      = c_id[0];
    assign second_valid = c_valid[1];
    assign second_price = c_price[1];
    assign full         = c_valid[BOOK_DEPTH-1];

endmodule

### test/limit_order_matcher_test.sv
// Self-checking testbench for the limit order matcher: random and directed orders.
module limit_order_matcher_test;
    import lom_pkg::*;

    localparam int DEPTH = BookDepthDef;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } order_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] order_id;
        logic [31:0] trade_num;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [31:0] exec_price;
        logic [31:0] exec_qty;
        logic        last;
    } fill_report_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    limit_order_matcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Predictor copy of both books: valid entries form a sorted prefix.
    logic [31:0] bid_px [DEPTH];
    logic [31:0] bid_qty[DEPTH];
    logic [31:0] bid_oid[DEPTH];
    int          bid_cnt;
    logic [31:0] ask_px [DEPTH];
    logic [31:0] ask_qty[DEPTH];
    logic [31:0] ask_oid[DEPTH];
    int          ask_cnt;
    logic [31:0] next_oid;
    logic [31:0] next_tid;

    order_t       pending_orders[$];
    fill_report_t expected_reports[$];
    int           error_count;
    bit           drv_quiet;     // no idling on the sender side
    bit           rcv_quiet;     // no idling on the receiver side
    bit           rcv_hold;      // long receiver hold-off in progress
    int           hold_cycles;
    int           idle_cycles;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic fill_report_t make_report(kind_t k, logic [31:0] oid,
            logic [31:0] tid, logic [31:0] b, logic [31:0] s, logic [31:0] px,
            logic [31:0] q);
        fill_report_t r;
        r.kind = k; r.order_id = oid; r.trade_num = tid; r.buy_id = b;
        r.sell_id = s; r.exec_price = px; r.exec_qty = q; r.last = 1'b0;
        return r;
    endfunction

    // Match one order against the opposite book, rest any remainder, and queue
    // the acknowledgement, trades and drop report it causes.
    task automatic match_order(order_t o);
        fill_report_t batch[$];
        logic [31:0] oid;
        logic [31:0] qty;
        logic [31:0] fill;
        int pos;
        bit is_sell;
        oid = next_oid;
        next_oid = next_oid + 1;
        is_sell = o.side;
        qty = o.quantity;
        batch.insert(batch.size(), make_report(KIND_ACK, oid, 0, 0, 0, 0, 0));
        if (is_sell) begin
            while (qty != 0 && bid_cnt > 0 && bid_px[0] >= o.price) begin
                fill = (bid_qty[0] < qty) ? bid_qty[0] : qty;
                batch.insert(batch.size(), make_report(KIND_TRADE, oid, next_tid,
                                                       bid_oid[0], oid, bid_px[0], fill));
                next_tid = next_tid + 1;
                qty = qty - fill;
                bid_qty[0] = bid_qty[0] - fill;
                if (bid_qty[0] == 0) begin
                    for (int i = 0; i + 1 < bid_cnt; i++) begin
                        bid_px[i] = bid_px[i+1]; bid_qty[i] = bid_qty[i+1];
                        bid_oid[i] = bid_oid[i+1];
                    end
                    bid_cnt--;
                end
            end
            if (qty != 0) begin
                if (ask_cnt < DEPTH) begin
                    pos = 0;
                    while (pos < ask_cnt && ask_px[pos] <= o.price) pos++;
                    for (int i = ask_cnt; i > pos; i--) begin
                        ask_px[i] = ask_px[i-1]; ask_qty[i] = ask_qty[i-1];
                        ask_oid[i] = ask_oid[i-1];
                    end
                    ask_px[pos] = o.price; ask_qty[pos] = qty; ask_oid[pos] = oid;
                    ask_cnt++;
                end else begin
                    batch.insert(batch.size(),
                                 make_report(KIND_DROP, oid, 0, 0, 0, o.price, qty));
                end
            end
        end else begin
            while (qty != 0 && ask_cnt > 0 && ask_px[0] <= o.price) begin
                fill = (ask_qty[0] < qty) ? ask_qty[0] : qty;
                batch.insert(batch.size(), make_report(KIND_TRADE, oid, next_tid,
                                                       oid, ask_oid[0], ask_px[0], fill));
                next_tid = next_tid + 1;
                qty = qty - fill;
                ask_qty[0] = ask_qty[0] - fill;
                if (ask_qty[0] == 0) begin
                    for (int i = 0; i + 1 < ask_cnt; i++) begin
                        ask_px[i] = ask_px[i+1]; ask_qty[i] = ask_qty[i+1];
                        ask_oid[i] = ask_oid[i+1];
                    end
                    ask_cnt--;
                end
            end
            if (qty != 0) begin
                if (bid_cnt < DEPTH) begin
                    pos = 0;
                    while (pos < bid_cnt && bid_px[pos] >= o.price) pos++;
                    for (int i = bid_cnt; i > pos; i--) begin
                        bid_px[i] = bid_px[i-1]; bid_qty[i] = bid_qty[i-1];
                        bid_oid[i] = bid_oid[i-1];
                    end
                    bid_px[pos] = o.price; bid_qty[pos] = qty; bid_oid[pos] = oid;
                    bid_cnt++;
                end else begin
                    batch.insert(batch.size(),
                                 make_report(KIND_DROP, oid, 0, 0, 0, o.price, qty));
                end
            end
        end
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected_reports.insert(expected_reports.size(), batch[i]);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic order_t make_order(logic side, logic [31:0] px, logic [31:0] q);
        order_t o;
        o.side = side; o.price = px; o.quantity = q;
        return o;
    endfunction

    // Prices sit in a narrow band so orders cross often; a few reach the extremes.
    function automatic order_t random_order();
        order_t o;
        int sel;
        o.side = $urandom_range(0, 1);
        sel = $urandom_range(0, 99);
        if (sel < 85) o.price = 1000 + $urandom_range(0, 20);
        else if (sel < 92) o.price = $urandom;
        else if (sel < 96) o.price = 32'hFFFF_FFFF;
        else o.price = 0;
        sel = $urandom_range(0, 99);
        if (sel < 80) o.quantity = $urandom_range(1, 50);
        else if (sel < 95) o.quantity = $urandom | 32'h1;
        else o.quantity = 32'hFFFF_FFFF;
        return o;
    endfunction

    // Driver: present the head of the pending queue; advance on each accepted beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                match_order(pending_orders.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat until it is taken
            end else if (pending_orders.size() > 0 &&
                         (drv_quiet || $urandom_range(0, 99) >= 37)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pending_orders[0].quantity, pending_orders[0].price,
                             pending_orders[0].side};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness, including the long hold-off that backs the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rcv_hold) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_tready <= rcv_quiet || ($urandom_range(0, 99) >= 37);
        end
    end

    // Monitor: compare each result beat with the oldest expected report.
    always @(posedge aclk) begin
        fill_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected beat, order_id", m_tdata[31:0], 0);
            end else begin
                want = expected_reports.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[31:0] != want.order_id)
                    report_mismatch("order_id", m_tdata[31:0], want.order_id);
                if (m_tdata[63:32] != want.trade_num)
                    report_mismatch("trade number", m_tdata[63:32], want.trade_num);
                if (m_tdata[95:64] != want.buy_id)
                    report_mismatch("buyer id", m_tdata[95:64], want.buy_id);
                if (m_tdata[127:96] != want.sell_id)
                    report_mismatch("seller id", m_tdata[127:96], want.sell_id);
                if (m_tdata[159:128] != want.exec_price)
                    report_mismatch("exec_price", m_tdata[159:128], want.exec_price);
                if (m_tdata[191:160] != want.exec_qty)
                    report_mismatch("exec_quantity", m_tdata[191:160], want.exec_qty);
                if (m_tlast != want.last)
                    report_mismatch("tlast", m_tlast, want.last);
            end
        end
    end

    // Watchdog: count cycles with no beat on either side, outside a receiver hold-off.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || rcv_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_orders.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        error_count = 0;
        drv_quiet = 0;
        rcv_quiet = 0;
        rcv_hold = 0;
        hold_cycles = 0;
        idle_cycles = 0;
        bid_cnt = 0;
        ask_cnt = 0;
        next_oid = 1;
        next_tid = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, partial fills on both sides, equal-price time priority.
        pending_orders.insert(pending_orders.size(), make_order(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_orders.insert(pending_orders.size(), make_order(1, 0, 32'hFFFF_FFFE));
        pending_orders.insert(pending_orders.size(), make_order(1, 0, 5));
        pending_orders.insert(pending_orders.size(), make_order(1, 100, 10));
        pending_orders.insert(pending_orders.size(), make_order(1, 100, 20));
        pending_orders.insert(pending_orders.size(), make_order(1, 99, 7));
        pending_orders.insert(pending_orders.size(), make_order(0, 100, 25));
        pending_orders.insert(pending_orders.size(), make_order(0, 50, 3));
        pending_orders.insert(pending_orders.size(), make_order(0, 50, 4));
        pending_orders.insert(pending_orders.size(), make_order(1, 40, 5));
        pending_orders.insert(pending_orders.size(), make_order(1, 32'hFFFF_FFFF, 1));
        pending_orders.insert(pending_orders.size(), make_order(0, 32'hFFFF_FFFF, 1));
        pending_orders.insert(pending_orders.size(), make_order(0, 0, 2));
        pending_orders.insert(pending_orders.size(), make_order(1, 0, 32'hFFFF_FFFF));
        wait_drained();

        // More buy orders than the bid book is deep, sent with no idling, then one large sell.
        drv_quiet = 1;
        for (int i = 0; i < DEPTH + 3; i++)
            pending_orders.insert(pending_orders.size(), make_order(0, 10 + (i % 5), 2));
        pending_orders.insert(pending_orders.size(), make_order(1, 0, 32'hFFFF_FFFF));
        wait_drained();
        drv_quiet = 0;

        // Long receiver hold-off while the sender keeps offering orders.
        rcv_hold = 1;
        for (int i = 0; i < 40; i++)
            pending_orders.insert(pending_orders.size(), random_order());
        wait (hold_cycles >= 300);
        rcv_hold = 0;
        wait_drained();

        // Random part, with a stretch free of idling on both sides.
        for (int i = 0; i < 160; i++) begin
            if (i == 60) begin
                rcv_quiet = 1; drv_quiet = 1;
            end
            if (i == 110) begin
                rcv_quiet = 0; drv_quiet = 0;
            end
            pending_orders.insert(pending_orders.size(), random_order());
            if (i % 50 == 49) wait_drained();
        end
        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### files.f
rtl/lom_pkg.sv
rtl/lom_cell.sv
rtl/lom_book.sv
rtl/limit_order_matcher.sv
test/limit_order_matcher_test.sv
